// ===== sv/sid_text_syntax_check_defines.svh =====
// ---------------------------------------------------------------------------
// sid_text_syntax_check_defines - assertion macros
// Short forms for the concurrent checks of the SID syntax checker.
// ---------------------------------------------------------------------------
`ifndef SID_TEXT_SYNTAX_CHECK_DEFINES_SVH
`define SID_TEXT_SYNTAX_CHECK_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SIDTC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SIDTC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sidtc_pkg.sv =====
// ---------------------------------------------------------------------------
// sidtc_pkg - shared types and constants
// Phase codes, limits and character codes of the SID syntax checker.
// ---------------------------------------------------------------------------
package sidtc_pkg;

    localparam int MAX_SUBAUTH = 15;
    localparam int MAX_LEN     = 256;

    localparam int PHASE_W = 4;
    localparam int GROUP_W = 5;
    localparam int COUNT_W = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [COUNT_W-1:0] LEN_LIMIT   = COUNT_W'(MAX_LEN);
    localparam logic [GROUP_W-1:0] GROUP_LIMIT = GROUP_W'(MAX_SUBAUTH);

    localparam logic [PHASE_W-1:0] PH_S     = 4'd0;
    localparam logic [PHASE_W-1:0] PH_DASH1 = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ONE   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_DASH2 = 4'd3;
    localparam logic [PHASE_W-1:0] PH_AUTH0 = 4'd4;
    localparam logic [PHASE_W-1:0] PH_AUTH  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_GRP0  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_GRP   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_FAIL  = 4'd8;

    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // One registered word on its way into the phase logic.
    typedef struct packed {
        logic       adv;
        logic [7:0] ch;
        logic       last;
    } sidtc_item_t;

endpackage

// ===== sv/sid_text_syntax_check.sv =====
// ---------------------------------------------------------------------------
// sid_text_syntax_check - SID text syntax checker
// Checks a character stream, one word per character, for the form
// S-1-<digits>(-<digits>){1..MAX_SUBAUTH}, at most MAX_LEN characters.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------
//   char     | char_valid / char_stall    | ch[7:0], last
//   result   | result_valid / result_stall| valid_res
//
// One character is taken per clock while char_stall is low. A character
// passes an input register, then the phase logic; a last character loads
// the result register as it leaves the input register. Reset clears the
// handshake state and returns the phase tracker to the start of a string.
// A stalled result holds the result register; a last character then waits
// in the input register and char_stall rises until the result is taken.
// ---------------------------------------------------------------------------
`include "sid_text_syntax_check_defines.svh"

module sid_text_syntax_check
    import sidtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] ch,
    input  logic       last,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       valid_res
);

    logic        item_valid_reg;
    logic [7:0]  ch_reg;
    logic        last_reg;
    logic        res_valid_reg;
    logic        res_reg;
    logic        res_free;
    logic        adv;
    logic        ok;
    sidtc_item_t item;

    assign res_free   = !res_valid_reg || !result_stall;
    assign adv        = item_valid_reg && (!last_reg || res_free);
    assign char_stall = item_valid_reg && !adv;

    assign item.adv  = adv;
    assign item.ch   = ch_reg;
    assign item.last = last_reg;

    sidtc_step u_step
    (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .ok    (ok)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                item_valid_reg <= 1'b0;
            end

            if (adv && last_reg)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
        if (adv && last_reg)
        begin
            res_reg <= ok;
        end
    end

    assign result_valid = res_valid_reg;
    assign valid_res    = res_reg;

    `SIDTC_ASSERT_NOW(a_stall_cause, char_stall,
        item_valid_reg && last_reg && res_valid_reg && result_stall,
        "char_stall without a blocked last word")
    `SIDTC_ASSERT_NEXT(a_last_gives_result, adv && last_reg, result_valid,
        "last word did not load the result register")
    `SIDTC_ASSERT_NOW(a_empty_no_stall, !item_valid_reg, !char_stall,
        "stall raised with an empty input register")

endmodule

// ===== sv/sidtc_step.sv =====
// ---------------------------------------------------------------------------
// sidtc_step - phase tracker
// Holds phase, group count and length count; steps them on each advancing
// word, clears them after a word marked last and gives the verdict for it.
// ---------------------------------------------------------------------------
module sidtc_step
    import sidtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sidtc_item_t item,
    output logic        ok
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [GROUP_W-1:0] group_reg, group_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               is_dec;
    logic               is_dash;

    assign is_dec  = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
    assign is_dash = (item.ch == CH_DASH);

    always_comb
    begin
        group_next = group_reg;
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        unique case (phase_reg)
            PH_S:     phase_next = (item.ch == CH_S)   ? PH_DASH1 : PH_FAIL;
            PH_DASH1: phase_next = is_dash             ? PH_ONE   : PH_FAIL;
            PH_ONE:   phase_next = (item.ch == CH_ONE) ? PH_DASH2 : PH_FAIL;
            PH_DASH2: phase_next = is_dash             ? PH_AUTH0 : PH_FAIL;
            PH_AUTH0: phase_next = is_dec              ? PH_AUTH  : PH_FAIL;
            PH_GRP0:  phase_next = is_dec              ? PH_GRP   : PH_FAIL;
            PH_AUTH, PH_GRP:
            begin
                if (is_dec)
                begin
                    phase_next = phase_reg;
                end
                else if (is_dash && (group_reg < GROUP_LIMIT))
                begin
                    phase_next = PH_GRP0;
                    group_next = group_reg + 1'b1;
                end
                else
                begin
                    phase_next = PH_FAIL;
                end
            end
            default:  phase_next = PH_FAIL;
        endcase
    end

    assign ok = (phase_next == PH_GRP) && (count_next <= LEN_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_S;
            group_reg <= '0;
            count_reg <= '0;
        end
        else if (item.adv)
        begin
            // drop back to the start of a string after its last word
            if (item.last)
            begin
                phase_reg <= PH_S;
                group_reg <= '0;
                count_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                group_reg <= group_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

// ===== dv/tb_sid_text_syntax_check.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sid_text_syntax_check - testbench for the SID text syntax checker
// Sends strings one character word at a time: well-formed identifiers,
// broken ones and random noise. A local copy of the phase tracker predicts
// the verdict of every string, and each result word is compared with the
// oldest prediction. The sender idles in bursts and the receiver stalls.
// ---------------------------------------------------------------------------
module tb_sid_text_syntax_check;
    import sidtc_pkg::*;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       char_valid   = 1'b0;
    logic       char_stall;
    logic [7:0] ch           = 8'h00;
    logic       last         = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic       valid_res;

    sid_text_syntax_check u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .ch           (ch),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .valid_res    (valid_res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted checker state and verdicts still to arrive
    logic [PHASE_W-1:0] phase_m  = PH_S;
    logic [GROUP_W-1:0] groups_m = '0;
    logic [COUNT_W-1:0] length_m = '0;
    logic               verdict_q[$];

    int err_cnt      = 0;
    int chars_sent   = 0;
    int strings_done = 0;
    int burst_left   = 0;

    logic [7:0] text_q[$];

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [PHASE_W-1:0] open_group();
        if (groups_m >= GROUP_LIMIT)
            return PH_FAIL;
        groups_m = groups_m + 1'b1;
        return PH_GRP0;
    endfunction

    function automatic logic [PHASE_W-1:0] next_phase(logic [PHASE_W-1:0] ph, logic [7:0] c);
        case (ph)
            PH_S:     return (c == CH_S)    ? PH_DASH1 : PH_FAIL;
            PH_DASH1: return (c == CH_DASH) ? PH_ONE   : PH_FAIL;
            PH_ONE:   return (c == CH_ONE)  ? PH_DASH2 : PH_FAIL;
            PH_DASH2: return (c == CH_DASH) ? PH_AUTH0 : PH_FAIL;
            PH_AUTH0: return is_digit(c)    ? PH_AUTH  : PH_FAIL;
            PH_AUTH, PH_GRP:
            begin
                if (is_digit(c))
                    return ph;
                if (c == CH_DASH)
                    return open_group();
                return PH_FAIL;
            end
            PH_GRP0:  return is_digit(c) ? PH_GRP : PH_FAIL;
            default:  return PH_FAIL;
        endcase
    endfunction

    // Advance the predicted tracker by one accepted character word
    function automatic void track_char(logic [7:0] c, logic l);
        if (length_m != COUNT_MAX)
            length_m = length_m + 1'b1;
        phase_m = next_phase(phase_m, c);
        if (l)
        begin
            verdict_q.push_back(phase_m == PH_GRP && length_m <= LEN_LIMIT);
            phase_m  = PH_S;
            groups_m = '0;
            length_m = '0;
            strings_done++;
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input logic l);
        if (burst_left == 0)
        begin
            // valid is low here: sit out a gap, then open a new burst
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
        end
        char_valid <= 1'b1;
        ch         <= c;
        last       <= l;
        do
            @(posedge clk);
        while (char_stall);
        track_char(c, l);
        chars_sent++;
        burst_left--;
        if (burst_left == 0)
            char_valid <= 1'b0;
    endtask

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic void put_digits(int n);
        repeat (n) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    // Result checking and receiver stall pattern
    int       pat_cnt    = 0;
    int       stall_mode = 0;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("valid_res: result word with no string pending, actual %0b", valid_res);
                err_cnt++;
            end
            else
            begin
                logic exp_v;
                exp_v = verdict_q.pop_front();
                if (valid_res !== exp_v)
                begin
                    $error("valid_res: expected %0b, actual %0b", exp_v, valid_res);
                    err_cnt++;
                end
            end
        end
        if (pat_cnt == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            pat_cnt    = $urandom_range(20, 120);
        end
        else
            pat_cnt--;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 3) == 0);
            2:       result_stall <= ($urandom_range(0, 9) < 7);
            default: result_stall <= pat_cnt[3];
        endcase
    end

    task automatic test_prefix_and_ends();
        put_text("S-1-5-0");   send_text();
        put_text("S-1-0-9");   send_text();
        put_text("S-1-5");     send_text();
        put_text("S-1-5-");    send_text();
        put_text("S");         send_text();
        text_q.push_back(8'h00); send_text();
        put_text("S-1-5-2"); text_q.push_back(8'h00); send_text();
        put_text("s-1-5-1");   send_text();
        put_text("S-2-5-1");   send_text();
        put_text("S-1--5");    send_text();
        put_text("S-1-5--1");  send_text();
        put_text("S-1-/-:");   send_text();
        // a bad character latches the failure for the rest of the string
        put_text("S-1-5"); text_q.push_back(8'hFF); put_text("-21"); send_text();
        put_text("S-1-12345-67-890"); send_text();
    endtask

    task automatic test_group_limit();
        put_text("S-1-5");
        repeat (MAX_SUBAUTH) put_text("-7");
        send_text();
        put_text("S-1-5");
        repeat (MAX_SUBAUTH + 1) put_text("-7");
        send_text();
        put_text("S-1-5");
        repeat (MAX_SUBAUTH) put_text("-7");
        text_q.push_back(CH_DASH);
        send_text();
    endtask

    task automatic test_length_limit();
        // prefix plus one authority digit takes five characters
        put_text("S-1-5-"); put_digits(MAX_LEN - 6); send_text();
        put_text("S-1-5-"); put_digits(MAX_LEN - 5); send_text();
        put_text("S-1-5-"); put_digits(520);         send_text();
        put_text("S-1-5-21"); send_text();
    endtask

    function automatic void build_random_string();
        int kind;
        int grp;
        int dmax;
        int idx;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom));
            return;
        end
        put_text("S-1-");
        put_digits($urandom_range(1, 4));
        if (kind < 20)
        begin
            grp  = $urandom_range(MAX_SUBAUTH - 1, MAX_SUBAUTH + 2);
            dmax = 3;
        end
        else
        begin
            grp  = $urandom_range(1, 5);
            dmax = 10;
        end
        repeat (grp)
        begin
            text_q.push_back(CH_DASH);
            put_digits($urandom_range(1, dmax));
        end
        if (kind >= 70)
        begin
            idx = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 4))
                0: text_q[idx] = 8'($urandom);
                1: text_q.insert(idx, 8'($urandom));
                2: if (text_q.size() > 1) text_q.delete(idx);
                3: while (text_q.size() > idx + 1) void'(text_q.pop_back());
                default: text_q.push_back(CH_DASH);
            endcase
        end
    endfunction

    task automatic test_random_strings();
        int chars_at_start;
        int strings_at_start;
        chars_at_start   = chars_sent;
        strings_at_start = strings_done;
        while (chars_sent - chars_at_start < 550 || strings_done - strings_at_start < 40)
        begin
            build_random_string();
            send_text();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_prefix_and_ends();
        test_group_limit();
        test_length_limit();
        test_random_strings();
        if (burst_left != 0)
            char_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/sidtc_pkg.sv
sv/sidtc_step.sv
sv/sid_text_syntax_check.sv
dv/tb_sid_text_syntax_check.sv
